// ===== rtl/core/bmmd_pkg.sv =====
// Shared types, widths and sizing functions for the block statistics unit.
package bmmd_pkg;

  localparam int unsigned SAMPLE_BITS = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [SAMPLE_BITS-1:0] dev_t;

  // Bits of a sample counter that must hold the full depth.
  function automatic int unsigned cnt_w(input int unsigned depth);
    return $clog2(depth + 1);
  endfunction

  // Bits of an index into one bank of the sample store.
  function automatic int unsigned idx_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Bits of the signed running sum over a full bank.
  function automatic int unsigned sum_w(input int unsigned depth);
    return SAMPLE_BITS + $clog2(depth);
  endfunction

endpackage

// ===== rtl/core/bmmd_in_if.sv =====
// Sample input channel: valid/ready handshake with the sample payload.
interface bmmd_in_if;
  logic              valid;
  logic              ready;
  bmmd_pkg::sample_t sample;
  logic              last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

// ===== rtl/core/bmmd_out_if.sv =====
// Result output channel: valid/ready handshake with the block statistics.
interface bmmd_out_if;
  logic              valid;
  logic              ready;
  bmmd_pkg::sample_t mean;
  bmmd_pkg::dev_t    max_deviation;
  bmmd_pkg::sample_t minimum;
  bmmd_pkg::sample_t maximum;
  logic              overflowed;

  modport source (output valid, mean, max_deviation, minimum, maximum, overflowed,
                  input ready);
  modport sink   (input valid, mean, max_deviation, minimum, maximum, overflowed,
                  output ready);
endinterface

// ===== rtl/core/bmmd_front.sv =====
// Front end: accepts samples, fills the store, keeps running sum, min and max.
module bmmd_front #(
  parameter int unsigned MAX_SAMPLES = 32,
  parameter int unsigned CNT_W       = bmmd_pkg::cnt_w(MAX_SAMPLES),
  parameter int unsigned IDX_W       = bmmd_pkg::idx_w(MAX_SAMPLES),
  parameter int unsigned SUM_W       = bmmd_pkg::sum_w(MAX_SAMPLES),
  parameter int unsigned JOB_W       = SUM_W + CNT_W + 2 * bmmd_pkg::SAMPLE_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmmd_in_if.sink           in_i,
  // store write port
  output logic              mem_we_o,
  output logic              mem_wbank_o,
  output logic [IDX_W-1:0]  mem_widx_o,
  output bmmd_pkg::sample_t mem_wdata_o,
  // job queue push side
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output logic [JOB_W-1:0]  job_o,
  // back end finished a job and released its bank
  input  logic              done_i
);

  typedef struct packed {
    logic                    bank;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    bmmd_pkg::sample_t       min;
    bmmd_pkg::sample_t       max;
    logic                    ovf;
  } job_t;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  bmmd_pkg::sample_t       min_q, max_q, min_d, max_d;
  logic                    ovf_q, ovf_d;
  logic                    bank_q;
  logic [1:0]              pend_q, pend_d;
  logic                    accept, room, first, push;
  bmmd_pkg::sample_t       s;
  job_t                    job;

  always_comb begin
    s      = in_i.sample;
    room   = cnt_q < CNT_W'(MAX_SAMPLES);
    first  = cnt_q == '0;
    // both banks busy: hold off until the back end releases one
    in_i.ready = (pend_q != 2'd2) && job_ready_i;
    accept = in_i.valid && in_i.ready;
    push   = accept && in_i.last_sample;

    sum_d = room ? sum_q + SUM_W'(s) : sum_q;
    cnt_d = room ? cnt_q + CNT_W'(1) : cnt_q;
    min_d = (room && (first || s < min_q)) ? s : min_q;
    max_d = (room && (first || s > max_q)) ? s : max_q;
    ovf_d = ovf_q | ~room;

    job.bank = bank_q;
    job.sum  = sum_d;
    job.cnt  = cnt_d;
    job.min  = min_d;
    job.max  = max_d;
    job.ovf  = ovf_d;

    job_valid_o = push;
    job_o       = job;

    mem_we_o    = accept && room;
    mem_wbank_o = bank_q;
    mem_widx_o  = cnt_q[IDX_W-1:0];
    mem_wdata_o = s;

    pend_d = pend_q;
    if (push && !done_i) begin
      pend_d = pend_q + 2'd1;
    end else if (!push && done_i) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        min_q <= min_d;
        max_q <= max_d;
        if (in_i.last_sample) begin
          // start the next block in the other bank
          sum_q  <= '0;
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
          bank_q <= ~bank_q;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
          ovf_q <= ovf_d;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bmmd_queue.sv =====
// Two-entry job queue between the front end and the back end.
module bmmd_queue #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       fill_q;
  logic             push, pop;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (!push && pop) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/bmmd_back.sv =====
// Back end: sample store, mean divider, deviation scan and result register.
module bmmd_back #(
  parameter int unsigned MAX_SAMPLES = 32,
  parameter int unsigned CNT_W       = bmmd_pkg::cnt_w(MAX_SAMPLES),
  parameter int unsigned IDX_W       = bmmd_pkg::idx_w(MAX_SAMPLES),
  parameter int unsigned SUM_W       = bmmd_pkg::sum_w(MAX_SAMPLES),
  parameter int unsigned JOB_W       = SUM_W + CNT_W + 2 * bmmd_pkg::SAMPLE_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // store write port from the front end
  input  logic              mem_we_i,
  input  logic              mem_wbank_i,
  input  logic [IDX_W-1:0]  mem_widx_i,
  input  bmmd_pkg::sample_t mem_wdata_i,
  // job queue pop side
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  logic [JOB_W-1:0]  job_i,
  bmmd_out_if.source        out_o,
  output logic              done_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);
  localparam int unsigned DIFF_W = bmmd_pkg::SAMPLE_BITS + 1;

  typedef struct packed {
    logic                    bank;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    bmmd_pkg::sample_t       min;
    bmmd_pkg::sample_t       max;
    logic                    ovf;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_SEND
  } state_e;

  bmmd_pkg::sample_t mem_q [2][MAX_SAMPLES];
  bmmd_pkg::sample_t rdata_q;

  state_e             state_q;
  job_t               job_q, job_in;
  logic [SUM_W-1:0]   quo_q, quo_d, sum_mag;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W:0]     rem_sh;
  logic               ge;
  logic [STEP_W-1:0]  step_q;
  logic [SUM_W-1:0]   mean_full;
  bmmd_pkg::sample_t  mean_q;
  bmmd_pkg::dev_t     dev_q;
  logic [CNT_W-1:0]   ridx_q;
  logic               rvld_q;
  logic               issue;
  logic signed [DIFF_W-1:0] diff, diff_abs;

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_wbank_i][mem_widx_i] <= mem_wdata_i;
    end
    rdata_q <= mem_q[job_q.bank][ridx_q[IDX_W-1:0]];
  end

  always_comb begin
    job_in  = job_i;
    sum_mag = job_in.sum[SUM_W-1] ? SUM_W'(-job_in.sum) : SUM_W'(job_in.sum);

    // restoring divide, one quotient bit per cycle
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    ge     = rem_sh >= {1'b0, job_q.cnt};
    rem_d  = ge ? CNT_W'(rem_sh - {1'b0, job_q.cnt}) : rem_sh[CNT_W-1:0];
    quo_d  = {quo_q[SUM_W-2:0], ge};
    mean_full = job_q.sum[SUM_W-1] ? SUM_W'(-quo_d) : quo_d;

    issue    = ridx_q < job_q.cnt;
    diff     = DIFF_W'(mean_q) - DIFF_W'(rdata_q);
    diff_abs = diff[DIFF_W-1] ? -diff : diff;

    job_ready_o = state_q == ST_IDLE;
    done_o      = (state_q == ST_SEND) && out_o.ready;

    out_o.valid         = state_q == ST_SEND;
    out_o.mean          = mean_q;
    out_o.max_deviation = dev_q;
    out_o.minimum       = job_q.min;
    out_o.maximum       = job_q.max;
    out_o.overflowed    = job_q.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      step_q  <= '0;
      mean_q  <= '0;
      dev_q   <= '0;
      ridx_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_in;
            quo_q   <= sum_mag;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q  <= quo_d;
          rem_q  <= rem_d;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SUM_W - 1)) begin
            mean_q  <= bmmd_pkg::sample_t'(mean_full[bmmd_pkg::SAMPLE_BITS-1:0]);
            dev_q   <= '0;
            ridx_q  <= '0;
            rvld_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // fold in the sample read last cycle
          if (rvld_q && bmmd_pkg::dev_t'(diff_abs) > dev_q) begin
            dev_q <= bmmd_pkg::dev_t'(diff_abs);
          end
          rvld_q <= issue;
          if (issue) begin
            ridx_q <= ridx_q + CNT_W'(1);
          end else begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/block_min_max_mean_deviation_unit.sv =====
// Block min/max/mean/deviation unit: top level.
// Samples are taken one per cycle unless both store banks are busy; two blocks may be
// in flight, one per store bank. After the last sample the back end divides the sum of
// a block of N stored samples by N, one quotient bit per cycle for SUM_W = 16 +
// clog2(MAX_SAMPLES) bits, then reads the store once per sample for the deviation.
// Reset is asynchronous, active low, and returns the unit to empty with no pending result.
module block_min_max_mean_deviation_unit #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  bmmd_in_if.sink    in_i,
  bmmd_out_if.source out_o
);

  localparam int unsigned CNT_W = bmmd_pkg::cnt_w(MAX_SAMPLES);
  localparam int unsigned IDX_W = bmmd_pkg::idx_w(MAX_SAMPLES);
  localparam int unsigned SUM_W = bmmd_pkg::sum_w(MAX_SAMPLES);
  localparam int unsigned JOB_W = SUM_W + CNT_W + 2 * bmmd_pkg::SAMPLE_BITS + 2;

  logic              mem_we;
  logic              mem_wbank;
  logic [IDX_W-1:0]  mem_widx;
  bmmd_pkg::sample_t mem_wdata;
  logic              push_valid, push_ready, pop_valid, pop_ready, done;
  logic [JOB_W-1:0]  push_data, pop_data;

  bmmd_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W),
    .SUM_W       (SUM_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_we_o    (mem_we),
    .mem_wbank_o (mem_wbank),
    .mem_widx_o  (mem_widx),
    .mem_wdata_o (mem_wdata),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_data),
    .done_i      (done)
  );

  bmmd_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bmmd_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W),
    .SUM_W       (SUM_W),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_we_i    (mem_we),
    .mem_wbank_i (mem_wbank),
    .mem_widx_i  (mem_widx),
    .mem_wdata_i (mem_wdata),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_data),
    .out_o       (out_o),
    .done_o      (done)
  );

endmodule

// ===== sim/tb_block_min_max_mean_deviation_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the block min/max/mean/deviation unit.
module tb_block_min_max_mean_deviation_unit;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned N_RANDOM   = 580;
  localparam int unsigned SETTLE_CYC = 64;
  localparam int unsigned MAX_REPORT = 10;

  typedef struct packed {
    bmmd_pkg::sample_t mean;
    bmmd_pkg::dev_t    max_deviation;
    bmmd_pkg::sample_t minimum;
    bmmd_pkg::sample_t maximum;
    logic              overflowed;
  } block_stats_t;

  logic clk_i;
  logic rst_ni;

  bmmd_in_if  in_if ();
  bmmd_out_if out_if ();

  block_min_max_mean_deviation_unit #(
    .MAX_SAMPLES(DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Running statistics of the block being loaded
  bmmd_pkg::sample_t held_samples [DEPTH];
  int                held_sum;
  int                held_count;
  bmmd_pkg::sample_t held_min;
  bmmd_pkg::sample_t held_max;
  logic              held_overflow;

  block_stats_t expected_stats_q [$];
  int unsigned  n_mismatch;
  int unsigned  n_sent;
  bit           no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic clear_held_block();
    held_sum      = 0;
    held_count    = 0;
    held_min      = '0;
    held_max      = '0;
    held_overflow = 1'b0;
  endtask

  // Fold one accepted sample into the block; on the last one queue the statistics.
  task automatic fold_sample(input bmmd_pkg::sample_t s, input logic last);
    block_stats_t st;
    int           mean;
    int           dev;
    int           d;
    int           i;
    if (held_count < DEPTH) begin
      held_samples[held_count] = s;
      if (held_count == 0 || s < held_min) held_min = s;
      if (held_count == 0 || s > held_max) held_max = s;
      held_sum += int'(s);
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      mean = held_sum / held_count;
      dev  = 0;
      for (i = 0; i < held_count; i++) begin
        d = mean - int'(held_samples[i]);
        if (d < 0) d = -d;
        if (d > dev) dev = d;
      end
      st.mean          = mean[bmmd_pkg::SAMPLE_BITS-1:0];
      st.max_deviation = dev[bmmd_pkg::SAMPLE_BITS-1:0];
      st.minimum       = held_min;
      st.maximum       = held_max;
      st.overflowed    = held_overflow;
      expected_stats_q.push_back(st);
      clear_held_block();
    end
  endtask

  task automatic send_sample(input bmmd_pkg::sample_t s, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.last_sample <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    fold_sample(s, last);
    n_sent++;
  endtask

  // Mostly full-range values, some rail values, some clustered near a block base.
  function automatic bmmd_pkg::sample_t draw_sample(input bmmd_pkg::sample_t base);
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    v = int'(base) + int'($urandom_range(0, 127)) - 64;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[bmmd_pkg::SAMPLE_BITS-1:0];
  endfunction

  task automatic test_single_sample_blocks();
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd1, 1'b1);
  endtask

  task automatic test_mean_truncation();
    // -3/2 truncates toward zero to -1
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32767, 1'b1);
    // one low outlier against a high mean: large deviation
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b1);
  endtask

  task automatic test_full_store();
    int k;
    for (k = 0; k < DEPTH; k++)
      send_sample((k % 2) ? 16'sd32767 : -16'sd32768, k == DEPTH - 1);
  endtask

  // Extra samples past the store depth are dropped; the last still closes the block.
  task automatic test_overflow();
    int k;
    for (k = 0; k < DEPTH + 3; k++)
      send_sample(draw_sample(16'sd0), k == DEPTH + 2);
    for (k = 0; k < DEPTH + 1; k++)
      send_sample(draw_sample(-16'sd20000), k == DEPTH);
  endtask

  task automatic test_random_blocks();
    int unsigned       stop_at;
    int                len;
    int                k;
    int unsigned       pick;
    bmmd_pkg::sample_t base;
    stop_at = n_sent + N_RANDOM;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 92) len = $urandom_range(9, DEPTH);
      else                len = $urandom_range(DEPTH + 1, DEPTH + 8);
      no_idle = ($urandom_range(0, 4) == 0);
      base    = draw_sample(16'sd0);
      for (k = 0; k < len; k++)
        send_sample(draw_sample(base), k == len - 1);
    end
    no_idle = 1'b0;
  endtask

  // Result sink: random stall before each transaction, none in quiet stretches
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_result
    block_stats_t got;
    block_stats_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{mean: out_if.mean, max_deviation: out_if.max_deviation,
              minimum: out_if.minimum, maximum: out_if.maximum,
              overflowed: out_if.overflowed};
      if (expected_stats_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORT)
          $display("%0t: result with no block pending: mean %0d dev %0d min %0d max %0d",
                   $realtime, got.mean, got.max_deviation, got.minimum, got.maximum,
                   " ovf %0b", got.overflowed);
      end else begin
        want = expected_stats_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORT) begin
            $display("%0t: stats mismatch", $realtime);
            $display("  expected mean %0d dev %0d min %0d max %0d ovf %0b",
                     want.mean, want.max_deviation, want.minimum, want.maximum,
                     want.overflowed);
            $display("  actual   mean %0d dev %0d min %0d max %0d ovf %0b",
                     got.mean, got.max_deviation, got.minimum, got.maximum,
                     got.overflowed);
          end
        end
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.last_sample <= 1'b0;
    no_idle    = 1'b0;
    n_mismatch = 0;
    n_sent     = 0;
    clear_held_block();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sample_blocks();
    test_mean_truncation();
    test_full_store();
    test_overflow();
    test_random_blocks();

    in_if.valid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (n_mismatch == 0 && expected_stats_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bmmd_pkg.sv
rtl/core/bmmd_in_if.sv
rtl/core/bmmd_out_if.sv
rtl/core/bmmd_front.sv
rtl/core/bmmd_queue.sv
rtl/core/bmmd_back.sv
rtl/core/block_min_max_mean_deviation_unit.sv
sim/tb_block_min_max_mean_deviation_unit.sv
